@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define GNB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GNB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/gnb_pkg.sv @@
// Shared constants, types and state codes of the gamma naive Bayes scorer.
`default_nettype none
package gnb_pkg;
    localparam int NUM_VARS = 4;
    localparam int MAX_VARS = 4;
    localparam int VAR_W = $clog2(MAX_VARS);
    localparam int CFG_IDX_W = $clog2(2 * MAX_VARS);
    localparam int DATA_W = 16;
    localparam int SCORE_W = 32;
    localparam int E_W = $clog2(DATA_W);
    localparam int M_W = 31;
    localparam int LN_STEPS = 28;
    localparam int FRAC_W = 28;
    localparam int C_W = 32;
    localparam int P_W = FRAC_W + C_W;
    localparam int LN_W = 40;
    localparam int LN_LAT = LN_STEPS + 3;
    localparam int ACC_W = 56;
    localparam int CA_W = DATA_W + 2;
    localparam int PROD_W = CA_W + LN_W;
    localparam int BX_W = 2 * DATA_W;
    localparam int RND_W = ACC_W - 16;
    localparam int ZSQ_W = 2 * DATA_W;
    localparam int Z3_W = 3 * DATA_W;
    localparam int DIV_W = 57;
    localparam int DIV_D_W = Z3_W + 9;
    localparam int DIV_R_W = DIV_D_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int INFL_W = 6;

    localparam logic [C_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [LN_W-1:0] LN2_X8 = $signed(LN_W'(LN2_Q32)) <<< 3;
    localparam logic signed [ACC_W-1:0] HALF_LN_2PI_Q32 = ACC_W'(64'sd3946810947);
    localparam logic [DATA_W-1:0] ONE_Q88 = 16'd256;
    localparam logic [DATA_W-1:0] HALF_Q88 = 16'd128;
    localparam logic [DATA_W-1:0] GAM_LIMIT = 16'd2048;
    localparam logic [DIV_W-1:0] DIV1_N = DIV_W'(1) << 40;
    localparam logic [DIV_W-1:0] DIV2_N = DIV_W'(1) << 56;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< 15;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef struct packed {
        logic [DATA_W-1:0] shape;
        logic [DATA_W-1:0] rate;
        logic signed [ACC_W-1:0] k;
        logic bad;
    } var_cfg_t;

    typedef struct packed {
        logic [MAX_VARS-1:0][DATA_W-1:0] sample;
        logic [MAX_VARS-1:0] nz;
        logic neg_inf;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic [Q_CNT_W-1:0] count;
    } front_status_t;

    typedef enum logic [3:0] {
        PR_IDLE,
        PR_LNB,
        PR_GAM,
        PR_LNC,
        PR_LNZ,
        PR_CUBE,
        PR_SCALE,
        PR_DIV1,
        PR_DIV2
    } prep_state_t;
endpackage
`default_nettype wire

@@ rtl/gnb_ln_pipe.sv @@
// Pipelined fixed-point natural log of an unsigned Q8.8 value, Q32 result.
`default_nettype none
module gnb_ln_pipe (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [gnb_pkg::DATA_W-1:0] in_v,
    output logic out_valid,
    output logic signed [gnb_pkg::LN_W-1:0] out_ln
);
    import gnb_pkg::*;

    logic [LN_STEPS:0] vld_reg;
    logic [E_W-1:0] e_reg [LN_STEPS+1];
    logic zero_reg [LN_STEPS+1];
    logic [M_W-1:0] m_reg [LN_STEPS+1];
    logic [FRAC_W-1:0] frac_reg [LN_STEPS+1];
    logic mul_vld_reg;
    logic mul_zero_reg;
    logic [P_W-1:0] p_reg;
    logic signed [LN_W-1:0] et_reg;
    logic out_valid_reg;
    logic signed [LN_W-1:0] out_ln_reg;
    logic [E_W-1:0] e_in;
    logic [47:0] m_sh;

    always_comb
    begin
        e_in = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (in_v[i])
            begin
                e_in = E_W'(i);
            end
        end
        m_sh = {32'b0, in_v} << (6'd30 - 6'(e_in));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            mul_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[LN_STEPS-1:0], in_valid};
            mul_vld_reg <= vld_reg[LN_STEPS];
            out_valid_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg[0] <= e_in;
        zero_reg[0] <= (in_v == '0);
        m_reg[0] <= m_sh[M_W-1:0];
        frac_reg[0] <= '0;
    end

    genvar s;
    generate
        for (s = 1; s <= LN_STEPS; s++)
        begin : g_step
            logic [2*M_W-1:0] prod;
            logic [M_W:0] sq;
            assign prod = {{M_W{1'b0}}, m_reg[s-1]} * {{M_W{1'b0}}, m_reg[s-1]};
            assign sq = prod[2*M_W-1:M_W-1];
            always_ff @(posedge clk)
            begin
                e_reg[s] <= e_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                if (sq[M_W])
                begin
                    m_reg[s] <= sq[M_W:1];
                    frac_reg[s] <= {frac_reg[s-1][FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    m_reg[s] <= sq[M_W-1:0];
                    frac_reg[s] <= {frac_reg[s-1][FRAC_W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        mul_zero_reg <= zero_reg[LN_STEPS];
        p_reg <= P_W'(frac_reg[LN_STEPS]) * P_W'(LN2_Q32);
        et_reg <= $signed(LN_W'(e_reg[LN_STEPS])) * $signed(LN_W'(LN2_Q32)) - LN2_X8;
        if (mul_zero_reg)
        begin
            out_ln_reg <= '0;
        end
        else
        begin
            out_ln_reg <= et_reg + $signed(LN_W'(p_reg[P_W-1:FRAC_W]));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ln = out_ln_reg;
endmodule
`default_nettype wire

@@ rtl/gnb_prep.sv @@
// Configuration registers and the sequencer that derives per-variable constants.
`default_nettype none
module gnb_prep (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [gnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gnb_pkg::DATA_W-1:0] cfg_data,
    output gnb_pkg::var_cfg_t var_cfg [gnb_pkg::MAX_VARS],
    output logic busy
);
    import gnb_pkg::*;

    prep_state_t state_reg;
    prep_state_t state_next;
    logic [DATA_W-1:0] shape_reg [MAX_VARS];
    logic [DATA_W-1:0] rate_reg [MAX_VARS];
    logic signed [ACC_W-1:0] k_reg [MAX_VARS];
    logic [MAX_VARS-1:0] bad_reg;
    logic [MAX_VARS-1:0] dirty_reg;
    logic [MAX_VARS-1:0] dirty_next;
    logic [VAR_W-1:0] idx_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] z_reg;
    logic signed [ACC_W-1:0] corr_reg;
    logic signed [ACC_W-1:0] t1_reg;
    logic signed [ACC_W-1:0] p_reg;
    logic signed [ACC_W-1:0] g_reg;
    logic [ZSQ_W-1:0] zsq_reg;
    logic [Z3_W-1:0] z3_reg;
    logic [DIV_D_W-1:0] d2_reg;
    logic [DIV_W-1:0] div_n_reg;
    logic [DIV_R_W-1:0] div_r_reg;
    logic [DIV_W-1:0] div_q_reg;
    logic [DIV_D_W-1:0] div_d_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic pick_valid;
    logic [VAR_W-1:0] pick_idx;
    logic [DATA_W-1:0] sel_shape;
    logic [DATA_W-1:0] sel_rate;
    logic ln_start;
    logic [DATA_W-1:0] ln_v;
    logic ln_valid;
    logic signed [LN_W-1:0] ln_out;
    logic [DIV_R_W-1:0] r_sh;
    logic div_ge;
    logic [DIV_R_W-1:0] r_new;
    logic [DIV_W-1:0] q_new;
    logic div_last;
    logic signed [ACC_W-1:0] z_term;
    logic signed [ACC_W-1:0] q_term;
    logic signed [CA_W-1:0] zc;
    logic [DIV_D_W-1:0] z3_ext;
    logic [DIV_D_W-1:0] z_ext;

    gnb_ln_pipe u_ln (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ln_start),
        .in_v      (ln_v),
        .out_valid (ln_valid),
        .out_ln    (ln_out)
    );

    always_comb
    begin
        pick_idx = '0;
        for (int i = MAX_VARS - 1; i >= 0; i--)
        begin
            if (dirty_reg[i])
            begin
                pick_idx = VAR_W'(i);
            end
        end
        pick_valid = |dirty_reg;
        sel_shape = shape_reg[pick_idx];
        sel_rate = rate_reg[pick_idx];
        r_sh = {div_r_reg[DIV_R_W-2:0], div_n_reg[DIV_W-1]};
        div_ge = r_sh >= {1'b0, div_d_reg};
        r_new = div_ge ? (r_sh - {1'b0, div_d_reg}) : r_sh;
        q_new = {div_q_reg[DIV_W-2:0], div_ge};
        div_last = (div_cnt_reg == DIV_CNT_W'(DIV_W - 1));
        z_term = $signed(ACC_W'(z_reg) << 24);
        q_term = $signed(ACC_W'(q_new));
        zc = $signed({2'b0, z_reg}) - $signed(CA_W'(HALF_Q88));
        z3_ext = DIV_D_W'(z3_reg);
        z_ext = DIV_D_W'(z_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        ln_start = 1'b0;
        ln_v = z_reg;
        dirty_next = dirty_reg;
        case (state_reg)
            PR_IDLE:
            begin
                if (pick_valid)
                begin
                    dirty_next[pick_idx] = 1'b0;
                    if (sel_shape != '0 && sel_rate != '0)
                    begin
                        ln_start = 1'b1;
                        ln_v = sel_rate;
                        state_next = PR_LNB;
                    end
                end
            end
            PR_LNB:
            begin
                if (ln_valid)
                begin
                    state_next = PR_GAM;
                end
            end
            PR_GAM:
            begin
                ln_start = 1'b1;
                state_next = (z_reg < GAM_LIMIT) ? PR_LNC : PR_LNZ;
            end
            PR_LNC:
            begin
                if (ln_valid)
                begin
                    state_next = PR_GAM;
                end
            end
            PR_LNZ:
            begin
                if (ln_valid)
                begin
                    state_next = PR_CUBE;
                end
            end
            PR_CUBE:
            begin
                state_next = PR_SCALE;
            end
            PR_SCALE:
            begin
                state_next = PR_DIV1;
            end
            PR_DIV1:
            begin
                if (div_last)
                begin
                    state_next = PR_DIV2;
                end
            end
            PR_DIV2:
            begin
                if (div_last)
                begin
                    state_next = PR_IDLE;
                end
            end
            default:
            begin
                state_next = PR_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            dirty_next[cfg_index[VAR_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PR_IDLE;
            dirty_reg <= '1;
            bad_reg <= '0;
            for (int i = 0; i < MAX_VARS; i++)
            begin
                shape_reg[i] <= ONE_Q88;
                rate_reg[i] <= ONE_Q88;
            end
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
            if (state_reg == PR_IDLE && pick_valid)
            begin
                bad_reg[pick_idx] <= (sel_shape == '0) || (sel_rate == '0);
            end
            if (cfg_we)
            begin
                if (cfg_index < CFG_IDX_W'(MAX_VARS))
                begin
                    shape_reg[cfg_index[VAR_W-1:0]] <= cfg_data;
                end
                else
                begin
                    rate_reg[cfg_index[VAR_W-1:0]] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            PR_IDLE:
            begin
                idx_reg <= pick_idx;
                a_reg <= sel_shape;
                z_reg <= sel_shape;
                corr_reg <= '0;
            end
            PR_LNB:
            begin
                if (ln_valid)
                begin
                    t1_reg <= ACC_W'($signed({1'b0, a_reg})) * ACC_W'(ln_out);
                end
            end
            PR_LNC:
            begin
                if (ln_valid)
                begin
                    corr_reg <= corr_reg + ACC_W'(ln_out);
                    z_reg <= z_reg + ONE_Q88;
                end
            end
            PR_LNZ:
            begin
                if (ln_valid)
                begin
                    p_reg <= ACC_W'(zc) * ACC_W'(ln_out);
                    zsq_reg <= ZSQ_W'(z_reg) * ZSQ_W'(z_reg);
                end
            end
            PR_CUBE:
            begin
                z3_reg <= Z3_W'(zsq_reg) * Z3_W'(z_reg);
            end
            PR_SCALE:
            begin
                d2_reg <= (z3_ext << 8) + (z3_ext << 6) + (z3_ext << 5) + (z3_ext << 3);
                div_d_reg <= (z_ext << 3) + (z_ext << 2);
                div_n_reg <= DIV1_N;
                div_r_reg <= '0;
                div_q_reg <= '0;
                div_cnt_reg <= '0;
            end
            PR_DIV1:
            begin
                if (div_last)
                begin
                    g_reg <= (p_reg >>> 8) - z_term + HALF_LN_2PI_Q32 + q_term - corr_reg;
                    div_d_reg <= d2_reg;
                    div_n_reg <= DIV2_N;
                    div_r_reg <= '0;
                    div_q_reg <= '0;
                    div_cnt_reg <= '0;
                end
                else
                begin
                    div_r_reg <= r_new;
                    div_n_reg <= div_n_reg << 1;
                    div_q_reg <= q_new;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
            end
            PR_DIV2:
            begin
                div_r_reg <= r_new;
                div_n_reg <= div_n_reg << 1;
                div_q_reg <= q_new;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    k_reg[idx_reg] <= (t1_reg >>> 8) - (g_reg - q_term);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_VARS; i++)
        begin
            var_cfg[i].shape = shape_reg[i];
            var_cfg[i].rate = rate_reg[i];
            var_cfg[i].k = k_reg[i];
            var_cfg[i].bad = bad_reg[i];
        end
    end

    assign busy = (state_reg != PR_IDLE) || (|dirty_reg);
endmodule
`default_nettype wire

@@ rtl/gnb_front.sv @@
// Front end: takes an input beat, flags zero samples and dead variables, and queues it.
`default_nettype none
module gnb_front (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic [gnb_pkg::DATA_W-1:0] sample [gnb_pkg::MAX_VARS],
    input  gnb_pkg::var_cfg_t var_cfg [gnb_pkg::MAX_VARS],
    output logic pop_valid,
    output gnb_pkg::entry_t pop_entry,
    output gnb_pkg::front_status_t status
);
    import gnb_pkg::*;

    logic in_vld_reg;
    entry_t in_entry_reg;
    entry_t in_entry_next;
    entry_t q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic push;
    logic pop;

    always_comb
    begin
        in_entry_next.neg_inf = 1'b0;
        for (int i = 0; i < MAX_VARS; i++)
        begin
            in_entry_next.sample[i] = sample[i];
            in_entry_next.nz[i] = (i < NUM_VARS) && (sample[i] != '0);
            if (in_entry_next.nz[i] && var_cfg[i].bad)
            begin
                in_entry_next.neg_inf = 1'b1;
            end
        end
    end

    assign push = in_vld_reg;
    assign pop = (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        in_entry_reg <= in_entry_next;
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_entry_reg;
        end
    end

    assign pop_valid = pop;
    assign pop_entry = q_mem[rd_ptr_reg];
    assign status.push = push;
    assign status.pop = pop;
    assign status.count = count_reg;
endmodule
`default_nettype wire

@@ rtl/gnb_back.sv @@
// Back end: per-variable log lanes, term assembly, sum, rounding and saturation.
`default_nettype none
module gnb_back (
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    input  gnb_pkg::entry_t pop_entry,
    input  gnb_pkg::var_cfg_t var_cfg [gnb_pkg::MAX_VARS],
    output logic done,
    output logic signed [gnb_pkg::SCORE_W-1:0] log_score
);
    import gnb_pkg::*;

    logic [NUM_VARS-1:0] ln_vld;
    logic signed [LN_W-1:0] ln_val [NUM_VARS];
    entry_t dl_reg [LN_LAT];
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic done_reg;
    logic signed [PROD_W-1:0] prod_reg [NUM_VARS];
    logic [BX_W-1:0] bx_reg [NUM_VARS];
    logic signed [ACC_W-1:0] t_reg [NUM_VARS];
    logic [MAX_VARS-1:0] nz1_reg;
    logic [MAX_VARS-1:0] nz2_reg;
    logic ninf1_reg;
    logic ninf2_reg;
    logic ninf3_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic signed [ACC_W-1:0] sum_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [ACC_W-1:0] rnd_full;
    logic signed [RND_W-1:0] rnd;
    logic signed [SCORE_W-1:0] score_next;

    genvar i;
    generate
        for (i = 0; i < NUM_VARS; i++)
        begin : g_lane
            logic signed [CA_W-1:0] ca;
            logic signed [ACC_W-1:0] bx_term;
            gnb_ln_pipe u_ln (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (pop_valid),
                .in_v      (pop_entry.sample[i]),
                .out_valid (ln_vld[i]),
                .out_ln    (ln_val[i])
            );
            assign ca = $signed({2'b0, var_cfg[i].shape}) - $signed(CA_W'(ONE_Q88));
            assign bx_term = $signed(ACC_W'(bx_reg[i]) << 16);
            always_ff @(posedge clk)
            begin
                prod_reg[i] <= PROD_W'(ca) * PROD_W'(ln_val[i]);
                bx_reg[i] <= BX_W'(var_cfg[i].rate) * BX_W'(dl_reg[LN_LAT-1].sample[i]);
                t_reg[i] <= var_cfg[i].k + ACC_W'(prod_reg[i] >>> 8) - bx_term;
            end
        end
    endgenerate

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < NUM_VARS; j++)
        begin
            if (nz2_reg[j])
            begin
                sum_next = sum_next + t_reg[j];
            end
        end
        rnd_full = (sum_reg + ROUND_HALF) >>> 16;
        rnd = rnd_full[RND_W-1:0];
        if (ninf3_reg || rnd < RND_W'(SCORE_MIN))
        begin
            score_next = SCORE_MIN;
        end
        else if (rnd > RND_W'(SCORE_MAX))
        begin
            score_next = SCORE_MAX;
        end
        else
        begin
            score_next = rnd[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= &ln_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg[0] <= pop_entry;
        for (int j = 1; j < LN_LAT; j++)
        begin
            dl_reg[j] <= dl_reg[j-1];
        end
        nz1_reg <= dl_reg[LN_LAT-1].nz;
        ninf1_reg <= dl_reg[LN_LAT-1].neg_inf;
        nz2_reg <= nz1_reg;
        ninf2_reg <= ninf1_reg;
        sum_reg <= sum_next;
        ninf3_reg <= ninf2_reg;
        score_reg <= score_next;
    end

    assign done = done_reg;
    assign log_score = score_reg;
endmodule
`default_nettype wire

@@ rtl/gamma_naive_bayes_log_score.sv @@
// Top level of the gamma naive Bayes log score: one feature vector in, one Q16.16 score out.
// Throughput: one vector per clock while busy is low; done pulses once per accepted vector.
// Latency is set by the 28-step square-and-compare log pipeline in each variable lane.
// After reset and after every register write busy stays high while the sequencer derives
// each changed variable's constant: up to 10 log passes plus two divisions per variable.
// Reset clears the control state and marks every variable for derivation.
`default_nettype none
`include "assert_macros.svh"
module gamma_naive_bayes_log_score (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [gnb_pkg::DATA_W-1:0] sample_0,
    input  logic [gnb_pkg::DATA_W-1:0] sample_1,
    input  logic [gnb_pkg::DATA_W-1:0] sample_2,
    input  logic [gnb_pkg::DATA_W-1:0] sample_3,
    output logic done,
    output logic signed [gnb_pkg::SCORE_W-1:0] log_score,
    input  logic cfg_we,
    input  logic [gnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gnb_pkg::DATA_W-1:0] cfg_data
);
    import gnb_pkg::*;

    logic [DATA_W-1:0] smp [MAX_VARS];
    var_cfg_t var_cfg [MAX_VARS];
    logic pop_valid;
    entry_t pop_entry;
    front_status_t fr_status;
    logic [INFL_W-1:0] inflight_reg;
    logic accept;

    assign smp[0] = sample_0;
    assign smp[1] = sample_1;
    assign smp[2] = sample_2;
    assign smp[3] = sample_3;
    assign accept = start && !busy;

    gnb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .var_cfg   (var_cfg),
        .busy      (busy)
    );

    gnb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (smp),
        .var_cfg   (var_cfg),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .status    (fr_status)
    );

    gnb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .var_cfg   (var_cfg),
        .done      (done),
        .log_score (log_score)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + INFL_W'(accept) - INFL_W'(done);
        end
    end

    `GNB_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, fr_status.push && !fr_status.pop, fr_status.count < Q_CNT_W'(Q_DEPTH), "front queue overflow")
    `GNB_ASSERT_IMPL(a_done_has_beat, clk, rst_n, done, inflight_reg != '0, "result without an accepted beat")
    `GNB_ASSERT_IMPL(a_inflight_bound, clk, rst_n, accept, inflight_reg != '1, "too many beats in flight")
endmodule
`default_nettype wire

@@ bench/gnb_score_checker.sv @@
// Checker for the gamma naive Bayes scorer: tracks registers, predicts scores and compares.
module gnb_score_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic [gnb_pkg::DATA_W-1:0] sample_0,
    input  logic [gnb_pkg::DATA_W-1:0] sample_1,
    input  logic [gnb_pkg::DATA_W-1:0] sample_2,
    input  logic [gnb_pkg::DATA_W-1:0] sample_3,
    input  logic done,
    input  logic signed [gnb_pkg::SCORE_W-1:0] log_score,
    input  logic cfg_we,
    input  logic [gnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gnb_pkg::DATA_W-1:0] cfg_data,
    output int errors,
    output int pending
);
    import gnb_pkg::*;

    localparam longint LN2_FIX = 64'sd2977044472;
    localparam longint HALF_LN_2PI_FIX = 64'sd3946810947;

    logic [DATA_W-1:0] shape_q [MAX_VARS];
    logic [DATA_W-1:0] rate_q [MAX_VARS];
    logic signed [SCORE_W-1:0] score_queue [$];
    int n_scored;

    function automatic longint nat_log_q32(input logic [31:0] v);
        int e;
        longint unsigned m;
        logic [31:0] frac;
        longint l2;
        e = 0;
        frac = '0;
        if (v == 0)
            return 0;
        for (int i = 0; i < 18; i++)
            if (v[i])
                e = i;
        m = longint'(v) << (30 - e);
        for (int i = 0; i < 28; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac[27 - i] = 1'b1;
            end
        end
        l2 = (longint'(e) - 8) * (longint'(1) << 28) + longint'(frac);
        return (l2 * LN2_FIX) >>> 28;
    endfunction

    function automatic longint log_gamma_q32(input logic [DATA_W-1:0] s);
        logic [31:0] z;
        longint corr;
        longint lz;
        longint res;
        longint unsigned zz;
        z = 32'(s);
        corr = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (z < 32'd2048)
            begin
                corr += nat_log_q32(z);
                z += 32'd256;
            end
        end
        lz = nat_log_q32(z);
        zz = longint'(z);
        res = ((longint'(z) - 128) * lz) >>> 8;
        res -= longint'(zz << 24);
        res += HALF_LN_2PI_FIX;
        res += longint'((64'd1 << 40) / (12 * zz));
        res -= longint'((64'd1 << 56) / (360 * zz * zz * zz));
        return res - corr;
    endfunction

    function automatic logic signed [SCORE_W-1:0] vector_score(
        input logic [MAX_VARS-1:0][DATA_W-1:0] x);
        longint sum;
        longint t;
        longint q;
        logic minus_inf;
        sum = 0;
        minus_inf = 1'b0;
        for (int i = 0; i < NUM_VARS; i++)
        begin
            if (x[i] != 0)
            begin
                if (shape_q[i] == 0 || rate_q[i] == 0)
                    minus_inf = 1'b1;
                else
                begin
                    t = (longint'(shape_q[i]) * nat_log_q32(32'(rate_q[i]))) >>> 8;
                    t += ((longint'(shape_q[i]) - 256) * nat_log_q32(32'(x[i]))) >>> 8;
                    t -= (longint'(rate_q[i]) * longint'(x[i])) << 16;
                    t -= log_gamma_q32(shape_q[i]);
                    sum += t;
                end
            end
        end
        if (minus_inf)
            return SCORE_MIN;
        q = (sum + (longint'(1) << 15)) >>> 16;
        if (q > longint'(SCORE_MAX))
            return SCORE_MAX;
        if (q < longint'(SCORE_MIN))
            return SCORE_MIN;
        return SCORE_W'(q);
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        n_scored = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VARS; i++)
            begin
                shape_q[i] <= ONE_Q88;
                rate_q[i] <= ONE_Q88;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index < MAX_VARS)
                shape_q[cfg_index] <= cfg_data;
            else
                rate_q[cfg_index - MAX_VARS] <= cfg_data;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (score_queue.size() == 0)
                    report($sformatf("score beat %0d with nothing expected", log_score));
                else
                begin
                    if (log_score !== score_queue[0])
                        report($sformatf("score %0d: got %0d, expected %0d", n_scored,
                            log_score, score_queue[0]));
                    void'(score_queue.pop_front());
                    n_scored++;
                end
            end
            if (start && !busy)
                score_queue.push_back(vector_score({sample_3, sample_2, sample_1, sample_0}));
            pending = score_queue.size();
        end
    end
endmodule

@@ bench/tb.sv @@
// Testbench top for the gamma naive Bayes scorer: stimulus, register phases and verdict.
module tb;
    import gnb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [DATA_W-1:0] sample_0 = '0;
    logic [DATA_W-1:0] sample_1 = '0;
    logic [DATA_W-1:0] sample_2 = '0;
    logic [DATA_W-1:0] sample_3 = '0;
    logic done;
    logic signed [SCORE_W-1:0] log_score;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    int errors;
    int pending;
    int cycles = 0;
    logic gaps_on;

    gamma_naive_bayes_log_score dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
        .done(done), .log_score(log_score),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gnb_score_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
        .done(done), .log_score(log_score),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return DATA_W'($urandom_range(1, 1023));
        if (r < 6)
            return DATA_W'($urandom_range(256, 4095));
        return DATA_W'($urandom);
    endfunction

    task automatic send_vector(input logic [DATA_W-1:0] s0, input logic [DATA_W-1:0] s1,
                               input logic [DATA_W-1:0] s2, input logic [DATA_W-1:0] s3);
        int gap;
        start <= 1'b1;
        sample_0 <= s0;
        sample_1 <= s1;
        sample_2 <= s2;
        sample_3 <= s3;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input logic [DATA_W-1:0] shapes [MAX_VARS],
                              input logic [DATA_W-1:0] rates [MAX_VARS]);
        for (int i = 0; i < 2 * MAX_VARS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= (i < MAX_VARS) ? shapes[i] : rates[i - MAX_VARS];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_vector(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    task automatic send_directed();
        send_vector('0, '0, '0, '0);
        send_vector(16'd1, 16'd1, 16'd1, 16'd1);
        send_vector('1, '1, '1, '1);
        send_vector(ONE_Q88, ONE_Q88, ONE_Q88, ONE_Q88);
        send_vector(16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00);
        send_vector(16'd1, '0, '1, '0);
        send_vector(16'd128, 16'd512, 16'd2048, 16'd1);
    endtask

    logic [DATA_W-1:0] shp [MAX_VARS];
    logic [DATA_W-1:0] rte [MAX_VARS];

    initial
    begin
        gaps_on = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        send_random(100);
        drain();
        for (int ph = 0; ph < 10; ph++)
        begin
            for (int i = 0; i < MAX_VARS; i++)
            begin
                case (ph)
                    0: begin shp[i] = 16'd1; rte[i] = 16'd1; end
                    1: begin shp[i] = '1; rte[i] = '1; end
                    2: begin shp[i] = '1; rte[i] = 16'd1; end
                    3: begin shp[i] = 16'd1; rte[i] = '1; end
                    4: begin
                        shp[i] = (i == 1) ? '0 : DATA_W'($urandom_range(1, 2047));
                        rte[i] = (i == 3) ? '0 : DATA_W'($urandom_range(1, 1023));
                    end
                    5, 6: begin
                        shp[i] = DATA_W'($urandom_range(1, 2047));
                        rte[i] = DATA_W'($urandom_range(1, 511));
                    end
                    default: begin
                        shp[i] = DATA_W'($urandom_range(1, 65535));
                        rte[i] = DATA_W'($urandom_range(1, 65535));
                    end
                endcase
            end
            write_regs(shp, rte);
            if (ph < 5)
                send_directed();
            send_random(100);
            if (ph == 6)
            begin
                drain();
                send_random(20);
            end
            drain();
        end
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
